### src/uart_rx_code_switch_defines.svh
// Assertion macros used by the result stream checker.
`ifndef UART_RX_CODE_SWITCH_DEFINES_SVH
`define UART_RX_CODE_SWITCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define URCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("urcs same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define URCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("urcs next-cycle check failed");

`endif

### src/urcs_pkg.sv
`default_nettype none

package urcs_pkg;

    // Tick counter width
    localparam int COUNT_WIDTH = 16;

    // Field widths
    localparam int HALF_W  = 16;
    localparam int CODE_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int BIT_W   = 3;
    localparam int HALFC_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Stream widths; the data widths are padded to whole bytes
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_CODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_CODE     = 2'd2;

    // Register reset values
    localparam logic [HALF_W-1:0] RST_HALF_BIT_TICKS = 16'd104;
    localparam logic [CODE_W-1:0] RST_LEFT_CODE      = 8'hBC;
    localparam logic [CODE_W-1:0] RST_RIGHT_CODE     = 8'hB2;

    // Match kinds
    localparam logic [KIND_W-1:0] MATCH_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] MATCH_LEFT  = 2'd1;
    localparam logic [KIND_W-1:0] MATCH_RIGHT = 2'd2;

    // Half periods to wait before the first and the later data bits
    localparam logic [HALFC_W-1:0] HALVES_FIRST = 2'd3;
    localparam logic [HALFC_W-1:0] HALVES_NEXT  = 2'd2;

    // Receiver phase, one-hot
    typedef enum logic [1:0] {
        PH_IDLE = 2'b01,
        PH_RECV = 2'b10
    } t_phase;

endpackage

`default_nettype wire

### src/uart_rx_code_switch.sv
`default_nettype none

// Serial 8N1 receiver that drives a shutter level. Each accepted input
// request is one sample of the receive line; each one gives exactly one
// result request in the next cycle through an output register, and a new
// sample is taken every cycle (one item per cycle, set by the single
// state update between the line sample and the output register; a
// stalled output holds the input only while the result is not taken).
// A falling edge in idle starts a byte; data bit 0 is sampled three half
// periods after the edge and bits 1..7 two half periods apart, LSB first,
// no stop-bit check. A finished byte equal to left_code sets the shutter,
// one equal to right_code clears it (left wins when both are equal).
// half_bit_ticks of zero acts as one. Configuration writes are always
// taken; unknown indexes are ignored.
module uart_rx_code_switch
    import urcs_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // configuration write channel
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    // line sample stream
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    input  wire  [S_TDATA_W-1:0]   i_s_tdata,   // [0] rx_line, [7:1] zero
    // result stream
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    output logic [M_TDATA_W-1:0]   o_m_tdata,   // [0] shutter_level, [8:1] byte_value,
                                                // [15:9] zero
    output logic [M_TUSER_W-1:0]   o_m_tuser    // [0] byte_done, [2:1] match_kind
);

    localparam int CMP_W = (COUNT_WIDTH > HALF_W) ? COUNT_WIDTH : HALF_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // configuration registers
    logic [HALF_W-1:0] r_half_bit_ticks;
    logic [CODE_W-1:0] r_left_code;
    logic [CODE_W-1:0] r_right_code;

    // receiver state
    t_phase                 r_phase,      n_phase;
    logic [COUNT_WIDTH-1:0] r_tick_count, n_tick_count;
    logic [HALFC_W-1:0]     r_half_count, n_half_count;
    logic [BIT_W-1:0]       r_bit_index,  n_bit_index;
    logic [BYTE_W-1:0]      r_shift_byte, n_shift_byte;
    logic                   r_prev_line,  n_prev_line;
    logic                   r_shutter,    n_shutter;

    // output register
    logic              r_out_valid, n_out_valid;
    logic              r_o_done,    n_o_done;
    logic [BYTE_W-1:0] r_o_value,   n_o_value;
    logic [KIND_W-1:0] r_o_kind,    n_o_kind;

    logic                   w_s_fire;
    logic                   w_line;
    logic [COUNT_WIDTH-1:0] w_half;
    logic [COUNT_WIDTH:0]   w_next_tick;
    logic [HALFC_W-1:0]     w_half_inc;
    logic [HALFC_W-1:0]     w_need;
    logic [BYTE_W-1:0]      w_sampled;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign w_s_fire    = i_s_tvalid && o_s_tready;
    assign w_line      = i_s_tdata[0];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_bit_ticks <= RST_HALF_BIT_TICKS;
            r_left_code      <= RST_LEFT_CODE;
            r_right_code     <= RST_RIGHT_CODE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HALF_BIT_TICKS: r_half_bit_ticks <= i_cfg_data[HALF_W-1:0];
                CFG_LEFT_CODE:      r_left_code      <= i_cfg_data[CODE_W-1:0];
                CFG_RIGHT_CODE:     r_right_code     <= i_cfg_data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // effective half period: zero acts as one, saturate to counter range
    always_comb begin
        if (r_half_bit_ticks == '0) begin
            w_half = COUNT_WIDTH'(1);
        end else if (CMP_W'(r_half_bit_ticks) > CMP_W'(COUNT_MAX)) begin
            w_half = COUNT_MAX;
        end else begin
            w_half = COUNT_WIDTH'(CMP_W'(r_half_bit_ticks));
        end
    end

    assign w_next_tick = {1'b0, r_tick_count} + (COUNT_WIDTH + 1)'(1);
    assign w_half_inc  = r_half_count + HALFC_W'(1);
    assign w_need      = (r_bit_index == '0) ? HALVES_FIRST : HALVES_NEXT;

    // shift register with the current sample placed at its bit
    always_comb begin
        w_sampled = r_shift_byte;
        w_sampled[r_bit_index] = r_shift_byte[r_bit_index] | w_line;
    end

    // per-sample state update
    always_comb begin
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_half_count = r_half_count;
        n_bit_index  = r_bit_index;
        n_shift_byte = r_shift_byte;
        n_prev_line  = r_prev_line;
        n_shutter    = r_shutter;
        n_o_done     = r_o_done;
        n_o_value    = r_o_value;
        n_o_kind     = r_o_kind;
        if (w_s_fire) begin
            n_o_done    = 1'b0;
            n_o_value   = '0;
            n_o_kind    = MATCH_NONE;
            n_prev_line = w_line;
            case (r_phase)
                PH_RECV: begin
                    if (w_next_tick >= {1'b0, w_half}) begin
                        n_tick_count = '0;
                        n_half_count = w_half_inc;
                        if (w_half_inc >= w_need) begin
                            n_half_count = '0;
                            n_shift_byte = w_sampled;
                            if (r_bit_index == '1) begin
                                // last data bit: deliver and compare
                                n_o_done    = 1'b1;
                                n_o_value   = w_sampled;
                                n_phase     = PH_IDLE;
                                n_bit_index = '0;
                                if (w_sampled == r_left_code) begin
                                    n_o_kind  = MATCH_LEFT;
                                    n_shutter = 1'b1;
                                end else if (w_sampled == r_right_code) begin
                                    n_o_kind  = MATCH_RIGHT;
                                    n_shutter = 1'b0;
                                end
                            end else begin
                                n_bit_index = r_bit_index + BIT_W'(1);
                            end
                        end
                    end else begin
                        n_tick_count = w_next_tick[COUNT_WIDTH-1:0];
                    end
                end
                default: begin
                    // idle: wait for the start edge
                    n_phase = PH_IDLE;
                    if (r_prev_line && !w_line) begin
                        n_phase      = PH_RECV;
                        n_tick_count = '0;
                        n_half_count = '0;
                        n_bit_index  = '0;
                        n_shift_byte = '0;
                    end
                end
            endcase
        end
    end

    // output handshake
    always_comb begin
        if (w_s_fire) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick_count <= '0;
            r_half_count <= '0;
            r_bit_index  <= '0;
            r_shift_byte <= '0;
            r_prev_line  <= 1'b1;
            r_shutter    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_half_count <= n_half_count;
            r_bit_index  <= n_bit_index;
            r_shift_byte <= n_shift_byte;
            r_prev_line  <= n_prev_line;
            r_shutter    <= n_shutter;
            r_out_valid  <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_o_done  <= n_o_done;
        r_o_value <= n_o_value;
        r_o_kind  <= n_o_kind;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_TDATA_W - BYTE_W - 1)'(0), r_o_value, r_shutter};
    assign o_m_tuser  = {r_o_kind, r_o_done};

endmodule

`default_nettype wire

### src/urcs_checker.sv
`default_nettype none

`include "uart_rx_code_switch_defines.svh"

// Port-level checks on the result stream.
module urcs_checker
    import urcs_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_m_tvalid,
    input wire                   i_m_tready,
    input wire [M_TDATA_W-1:0]   i_m_tdata,
    input wire [M_TUSER_W-1:0]   i_m_tuser
);

    logic              w_done;
    logic [KIND_W-1:0] w_kind;
    logic [BYTE_W-1:0] w_value;
    logic              w_shutter;

    assign w_done    = i_m_tuser[0];
    assign w_kind    = i_m_tuser[KIND_W:1];
    assign w_value   = i_m_tdata[BYTE_W:1];
    assign w_shutter = i_m_tdata[0];

    // a match is only reported with a finished byte
    `URCS_ASSERT_IMPLY(a_kind_needs_done, i_clk, i_rst_n,
        i_m_tvalid && (w_kind != MATCH_NONE), w_done)

    // no byte value without a finished byte
    `URCS_ASSERT_IMPLY(a_value_zero_idle, i_clk, i_rst_n,
        i_m_tvalid && !w_done, w_value == '0)

    // shutter level follows the matched code
    `URCS_ASSERT_IMPLY(a_shutter_follows, i_clk, i_rst_n,
        i_m_tvalid && ((w_kind == MATCH_LEFT) || (w_kind == MATCH_RIGHT)),
        w_shutter == (w_kind == MATCH_LEFT))

    // stalled result request holds
    `URCS_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n,
        i_m_tvalid && !i_m_tready,
        i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))

endmodule

bind uart_rx_code_switch urcs_checker u_urcs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);

`default_nettype wire

### tb/uart_rx_code_switch_checker.sv
`timescale 1ns / 1ps

// Watches the config, sample and result channels of uart_rx_code_switch,
// keeps its own copy of the receiver and the registers, and compares each
// result request with the oldest predicted one.
module uart_rx_code_switch_checker
    import urcs_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_valid,
    input  wire                    i_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                    i_s_tvalid,
    input  wire                    i_s_tready,
    input  wire  [S_TDATA_W-1:0]   i_s_tdata,   // [0] rx_line, [7:1] zero
    input  wire                    i_m_tvalid,
    input  wire                    i_m_tready,
    input  wire  [M_TDATA_W-1:0]   i_m_tdata,   // [0] shutter_level, [8:1] byte_value,
                                                // [15:9] zero
    input  wire  [M_TUSER_W-1:0]   i_m_tuser,   // [0] byte_done, [2:1] match_kind
    output int                     o_mismatches,
    output int                     o_pending
);

    typedef struct packed {
        logic              shutter;
        logic              done;
        logic [BYTE_W-1:0] value;
        logic [KIND_W-1:0] kind;
    } t_line_result;

    // shadow registers
    logic [HALF_W-1:0]      half_ticks;
    logic [CODE_W-1:0]      set_code;
    logic [CODE_W-1:0]      clear_code;

    // shadow receiver
    t_phase                 rx_phase;
    logic [COUNT_WIDTH-1:0] tick_cnt;
    logic [HALFC_W-1:0]     half_cnt;
    logic [BIT_W-1:0]       bit_pos;
    logic [BYTE_W-1:0]      rx_byte;
    logic                   last_line;
    logic                   shutter;

    t_line_result           line_results_q[$];
    t_line_result           predicted;
    t_line_result           observed;
    t_line_result           oldest;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // One line sample through the receiver; returns the result it gives.
    task automatic advance_receiver(input logic line, output t_line_result res);
        int                 eff;
        int                 nxt;
        logic [HALFC_W-1:0] need;
        res = '0;
        if (rx_phase == PH_RECV) begin
            eff = (half_ticks == '0) ? 1 : int'(half_ticks);
            if (eff > (1 << COUNT_WIDTH) - 1)
                eff = (1 << COUNT_WIDTH) - 1;
            nxt = int'(tick_cnt) + 1;
            if (nxt >= eff) begin
                need     = (bit_pos == '0) ? HALVES_FIRST : HALVES_NEXT;
                tick_cnt = '0;
                half_cnt = half_cnt + 1'b1;
                if (half_cnt >= need) begin
                    half_cnt         = '0;
                    rx_byte[bit_pos] = rx_byte[bit_pos] | line;
                    if (bit_pos == 3'd7) begin
                        res.done  = 1'b1;
                        res.value = rx_byte;
                        // left code wins when both codes are equal
                        if (rx_byte == set_code) begin
                            res.kind = MATCH_LEFT;
                            shutter  = 1'b1;
                        end else if (rx_byte == clear_code) begin
                            res.kind = MATCH_RIGHT;
                            shutter  = 1'b0;
                        end
                        rx_phase = PH_IDLE;
                        bit_pos  = '0;
                    end else begin
                        bit_pos = bit_pos + 1'b1;
                    end
                end
            end else begin
                tick_cnt = COUNT_WIDTH'(nxt);
            end
        end else begin
            rx_phase = PH_IDLE;
            // falling edge marks the start bit
            if (last_line && !line) begin
                rx_phase = PH_RECV;
                tick_cnt = '0;
                half_cnt = '0;
                bit_pos  = '0;
                rx_byte  = '0;
            end
        end
        last_line   = line;
        res.shutter = shutter;
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            half_ticks = RST_HALF_BIT_TICKS;
            set_code   = RST_LEFT_CODE;
            clear_code = RST_RIGHT_CODE;
            rx_phase   = PH_IDLE;
            tick_cnt   = '0;
            half_cnt   = '0;
            bit_pos    = '0;
            rx_byte    = '0;
            last_line  = 1'b1;
            shutter    = 1'b0;
            line_results_q.delete();
        end else begin
            // register writes; unknown indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HALF_BIT_TICKS: half_ticks = i_cfg_data[HALF_W-1:0];
                    CFG_LEFT_CODE:      set_code   = i_cfg_data[CODE_W-1:0];
                    CFG_RIGHT_CODE:     clear_code = i_cfg_data[CODE_W-1:0];
                    default: ;
                endcase
            end

            if (i_s_tvalid && i_s_tready) begin
                advance_receiver(i_s_tdata[0], predicted);
                line_results_q.push_back(predicted);
            end

            // compare result requests in order
            if (i_m_tvalid && i_m_tready) begin
                observed.shutter = i_m_tdata[0];
                observed.value   = i_m_tdata[8:1];
                observed.done    = i_m_tuser[0];
                observed.kind    = i_m_tuser[2:1];
                if (line_results_q.size() == 0) begin
                    $error("result request with no sample waiting for it");
                    o_mismatches++;
                end else begin
                    oldest = line_results_q.pop_front();
                    check_field("shutter_level", oldest.shutter, observed.shutter);
                    check_field("byte_done", oldest.done, observed.done);
                    check_field("byte_value", oldest.value, observed.value);
                    check_field("match_kind", oldest.kind, observed.kind);
                end
            end
        end
        o_pending = line_results_q.size();
    end

endmodule

### tb/tb_uart_rx_code_switch.sv
`timescale 1ns / 1ps

module tb_uart_rx_code_switch;
    import urcs_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int IDLE_LIMIT   = 3000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 400;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [M_TDATA_W-1:0]   o_m_tdata;
    logic [M_TUSER_W-1:0]   o_m_tuser;

    int                     mismatches;
    int                     pending;
    int                     samples_taken;
    int                     idle_cycles;
    bit                     sender_bursty;
    bit                     pressure_armed;

    uart_rx_code_switch DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    uart_rx_code_switch_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Result side: ready runs and stalls, one long hold once the random part starts.
    initial begin
        int  run_left;
        int  stall_left;
        bit  long_hold_done;
        run_left       = 0;
        stall_left     = 0;
        long_hold_done = 0;
        i_m_tready     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pressure_armed && !long_hold_done) begin
                long_hold_done = 1;
                run_left       = 0;
                stall_left     = LONG_HOLD;
            end
            if (run_left == 0 && stall_left == 0) begin
                run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                         : $urandom_range(1, 30);
                stall_left = pick_gap();
            end
            if (run_left > 0) begin
                i_m_tready <= 1'b1;
                run_left--;
            end else begin
                i_m_tready <= 1'b0;
                stall_left--;
            end
        end
    end

    // Cycles without any accepted request
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One line sample; valid stays high when the next one follows at once.
    task automatic send_sample(input logic line);
        int gap;
        gap = sender_bursty ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_TDATA_W-1){1'b0}}, line};
        do @(posedge i_clk); while (!o_s_tready);
        samples_taken++;
        @(negedge i_clk);
    endtask

    // 8N1 frame over 20 half periods; glitches land only off the sample ticks.
    task automatic send_frame(input logic [7:0] data, input int half, input bit glitchy);
        int   hh;
        int   t;
        bit   on_sample;
        logic line;
        hh = (half < 1) ? 1 : half;
        send_sample(1'b1);
        for (t = 0; t < 20 * hh; t++) begin
            if (t < 2 * hh)
                line = 1'b0;
            else if (t < 18 * hh)
                line = data[(t - 2 * hh) / (2 * hh)];
            else
                line = 1'b1;
            on_sample = (t >= 3 * hh) && ((t - 3 * hh) % (2 * hh) == 0);
            if (glitchy && t > 0 && t < 17 * hh && !on_sample && $urandom_range(0, 7) == 0)
                line = ~line;
            send_sample(line);
        end
    endtask

    // Random line noise, then enough idle line for any byte in progress to end.
    task automatic send_noise(input int half);
        int hh;
        int n;
        hh = (half < 1) ? 1 : half;
        n  = $urandom_range(4, 40);
        repeat (n) send_sample(1'($urandom));
        repeat (17 * hh + 2) send_sample(1'b1);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Writes all three registers back to back, optionally with an unused index first.
    task automatic configure(input logic [15:0] half, input logic [15:0] left_w,
                             input logic [15:0] right_w, input bit with_unused);
        logic [CFG_IDX_W-1:0]  idx[4];
        logic [CFG_DATA_W-1:0] val[4];
        int                    n;
        int                    k;
        n = 0;
        if (with_unused) begin
            idx[n] = CFG_UNUSED;
            val[n] = 16'($urandom);
            n++;
        end
        idx[n] = CFG_HALF_BIT_TICKS; val[n] = half;    n++;
        idx[n] = CFG_LEFT_CODE;      val[n] = left_w;  n++;
        idx[n] = CFG_RIGHT_CODE;     val[n] = right_w; n++;
        for (k = 0; k < n; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Stimulus and verdict
    initial begin
        int          phase_end;
        int          random_end;
        int          half;
        logic [7:0]  left_c;
        logic [7:0]  right_c;
        logic [7:0]  data;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        samples_taken  = 0;
        idle_cycles    = 0;
        sender_bursty  = 1'b0;
        pressure_armed = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset codes, with only the half period shortened
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_HALF_BIT_TICKS;
        i_cfg_data  <= 16'd1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        sender_bursty = 1'b1;
        send_frame(8'hBC, 1, 1'b0);
        send_frame(8'hB2, 1, 1'b0);
        wait_drained();

        // zero half period acts as one; code extremes; unused index ignored
        configure(16'd0, 16'h0000, 16'h00FF, 1'b1);
        sender_bursty = 1'b0;
        send_frame(8'h00, 0, 1'b0);
        send_frame(8'hFF, 0, 1'b0);
        send_frame(8'h5A, 0, 1'b0);
        send_frame(8'hA5, 0, 1'b1);
        wait_drained();

        // equal codes count as left
        configure(16'd2, 16'hFF3C, 16'h003C, 1'b0);
        send_frame(8'h3C, 2, 1'b0);
        send_frame(8'h00, 2, 1'b1);
        wait_drained();

        // start edge right after a stop bit, then noise after the bytes
        configure(16'd1, 16'h0081, 16'h007E, 1'b0);
        send_frame(8'h81, 1, 1'b0);
        send_frame(8'h7E, 1, 1'b0);
        send_noise(1);
        wait_drained();

        // random settings with mostly well-formed frames
        pressure_armed = 1'b1;
        random_end     = samples_taken + RANDOM_ITEMS;
        while (samples_taken < random_end) begin
            case ($urandom_range(0, 7))
                0:       half = 0;
                1, 2:    half = 1;
                3, 4:    half = 2;
                5:       half = 3;
                6:       half = 4;
                default: half = 6;
            endcase
            left_c  = 8'($urandom);
            right_c = ($urandom_range(0, 5) == 0) ? left_c : 8'($urandom);
            configure(16'(half), {8'($urandom), left_c}, {8'($urandom), right_c},
                      $urandom_range(0, 3) == 0);
            sender_bursty = ($urandom_range(0, 2) == 0);
            phase_end     = samples_taken + $urandom_range(150, 250);
            while (samples_taken < phase_end) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_noise(half);
                end else begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4: data = left_c;
                        5, 6, 7, 8:    data = right_c;
                        9:             data = 8'h00;
                        10:            data = 8'hFF;
                        default:       data = 8'($urandom);
                    endcase
                    send_frame(data, half, $urandom_range(0, 9) < 3);
                end
            end
            wait_drained();
        end

        // longest half period: a byte starts and stays in progress to the end
        configure(16'hFFFF, 16'h00FF, 16'hFF00, 1'b0);
        sender_bursty = 1'b0;
        send_sample(1'b1);
        send_sample(1'b0);
        repeat (40) send_sample(1'($urandom));
        wait_drained();
        repeat (4) @(negedge i_clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### uart_rx_code_switch.f
+incdir+src
src/urcs_pkg.sv
src/uart_rx_code_switch.sv
src/urcs_checker.sv
tb/uart_rx_code_switch_checker.sv
tb/tb_uart_rx_code_switch.sv
